@@ rtl/rwbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Reaction wheel balance controller package
// Shared constants, register codes and the structs that pass between the
// pipeline stages of the cascaded angle PID / wheel speed PI controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rwbc_pkg;

  // Fixed controller limits.
  localparam int ANGLE_INTEGRAL_LIMIT = 3840;
  localparam int SPEED_INTEGRAL_LIMIT = 2000;
  localparam int SPEED_INT_LIMIT_Q8   = SPEED_INTEGRAL_LIMIT * 256;
  localparam int DEAD_ZONE_OFFSET     = 800;
  localparam int ZERO_BAND            = 1000;

  // Division by ten as a reciprocal multiply: exact for magnitudes below 2^27.
  localparam int DIV10_RECIP = 107374183;
  localparam int DIV10_SHIFT = 30;

  // Configuration register reset values.
  localparam logic signed [15:0] RST_PITCH_SETPOINT = 16'sd896;
  localparam logic [19:0] RST_ANGLE_KP   = 20'd486400;
  localparam logic [19:0] RST_ANGLE_KI   = 20'd819;
  localparam logic [19:0] RST_ANGLE_KD   = 20'd15360;
  localparam logic [19:0] RST_SPEED_KP   = 20'd23040;
  localparam logic [19:0] RST_SPEED_KI   = 20'd256;
  localparam logic [14:0] RST_TILT_LIMIT = 15'd2560;
  localparam logic [13:0] RST_DUTY_LIMIT = 14'd8000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PITCH_SETPOINT = 3'd0,
    REG_ANGLE_KP       = 3'd1,
    REG_ANGLE_KI       = 3'd2,
    REG_ANGLE_KD       = 3'd3,
    REG_SPEED_KP       = 3'd4,
    REG_SPEED_KI       = 3'd5,
    REG_TILT_LIMIT     = 3'd6,
    REG_DUTY_LIMIT     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] pitch_setpoint;
    logic [19:0]        angle_kp;
    logic [19:0]        angle_ki;
    logic [19:0]        angle_kd;
    logic [19:0]        speed_kp;
    logic [19:0]        speed_ki;
    logic [14:0]        tilt_limit;
    logic [13:0]        duty_limit;
  } cfg_t;

  // Input register contents.
  typedef struct packed {
    logic               valid;
    logic signed [15:0] pitch;
    logic signed [15:0] gyro_rate;
    logic signed [15:0] wheel_count;
    logic               run_enable;
  } input_t;

  // Loop state after both integrators have been updated.
  typedef struct packed {
    logic               valid;
    logic               run_enable;
    logic               fallen;
    logic signed [16:0] bias;
    logic signed [12:0] angle_integral;
    logic signed [15:0] gyro_rate;
    logic signed [23:0] speed_filtered;
    logic signed [19:0] speed_integral;
  } loop_state_t;

  // Angle term and speed products.
  typedef struct packed {
    logic               valid;
    logic               run_enable;
    logic               fallen;
    logic signed [29:0] angle_term;
    logic signed [44:0] speed_p;
    logic signed [40:0] speed_i;
  } terms_t;

  // Output register contents.
  typedef struct packed {
    logic               valid;
    logic               fallen;
    logic signed [14:0] motor_duty;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/reaction_wheel_balance_controller_core.sv @@
// Registers in order: input, filter, loop state, products, terms, sum, output.
// Throughput: one item per cycle; the seven register stages advance together
// whenever the output register is empty or being read.
// Reset (rst, synchronous, active high) clears all valid flags, the angle and
// speed integrators and the speed filter, and loads the register defaults.
// ----------------------------------------------------------------------------
// Reaction wheel balance controller core
// Cascaded angle PID and wheel speed PI producing a signed motor duty and a
// fall flag per control tick, on stream interfaces with a config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module reaction_wheel_balance_controller_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output wire logic        s_tready,
  // pitch[15:0], gyro_rate[31:16], wheel_count[47:32], run_enable[48], zero pad
  input  wire logic [55:0] s_tdata,
  output wire logic        m_tvalid,
  input  wire logic        m_tready,
  // motor_duty[14:0], fallen[15]
  output wire logic [15:0] m_tdata,
  input  wire logic        cfg_valid,
  output wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  rwbc_pkg::cfg_t        cfg;
  rwbc_pkg::input_t      in_stage;
  rwbc_pkg::loop_state_t loop_stage;
  rwbc_pkg::terms_t      term_stage;
  rwbc_pkg::result_t     result;
  logic                  en;

  // The whole pipeline moves unless a finished result is held back.
  assign en        = !result.valid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  rwbc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_stage.valid <= 1'b0;
    end else if (en) begin
      in_stage.valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_stage.pitch       <= s_tdata[15:0];
      in_stage.gyro_rate   <= s_tdata[31:16];
      in_stage.wheel_count <= s_tdata[47:32];
      in_stage.run_enable  <= s_tdata[48];
    end
  end

  rwbc_state_update u_state_update (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_stage  (in_stage),
    .cfg       (cfg),
    .out_stage (loop_stage)
  );

  rwbc_gain_mult u_gain_mult (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_stage  (loop_stage),
    .cfg       (cfg),
    .out_stage (term_stage)
  );

  rwbc_duty_shaper u_duty_shaper (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_stage (term_stage),
    .cfg      (cfg),
    .result   (result)
  );

  assign m_tvalid = result.valid;
  assign m_tdata  = {result.fallen, result.motor_duty};

endmodule

`default_nettype wire

@@ rtl/rwbc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the set point, loop gains and limits; written one register per
// transaction on the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rwbc_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  output rwbc_pkg::cfg_t   cfg
);

  // Register writes, one index per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pitch_setpoint <= rwbc_pkg::RST_PITCH_SETPOINT;
      cfg.angle_kp       <= rwbc_pkg::RST_ANGLE_KP;
      cfg.angle_ki       <= rwbc_pkg::RST_ANGLE_KI;
      cfg.angle_kd       <= rwbc_pkg::RST_ANGLE_KD;
      cfg.speed_kp       <= rwbc_pkg::RST_SPEED_KP;
      cfg.speed_ki       <= rwbc_pkg::RST_SPEED_KI;
      cfg.tilt_limit     <= rwbc_pkg::RST_TILT_LIMIT;
      cfg.duty_limit     <= rwbc_pkg::RST_DUTY_LIMIT;
    end else if (cfg_valid) begin
      case (rwbc_pkg::cfg_reg_t'(cfg_index))
        rwbc_pkg::REG_PITCH_SETPOINT: cfg.pitch_setpoint <= cfg_data[15:0];
        rwbc_pkg::REG_ANGLE_KP:       cfg.angle_kp       <= cfg_data;
        rwbc_pkg::REG_ANGLE_KI:       cfg.angle_ki       <= cfg_data;
        rwbc_pkg::REG_ANGLE_KD:       cfg.angle_kd       <= cfg_data;
        rwbc_pkg::REG_SPEED_KP:       cfg.speed_kp       <= cfg_data;
        rwbc_pkg::REG_SPEED_KI:       cfg.speed_ki       <= cfg_data;
        rwbc_pkg::REG_TILT_LIMIT:     cfg.tilt_limit     <= cfg_data[14:0];
        rwbc_pkg::REG_DUTY_LIMIT:     cfg.duty_limit     <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/rwbc_state_update.sv @@
// ----------------------------------------------------------------------------
// Loop state update
// Updates the angle integral and the wheel speed filter in one stage and the
// wheel speed integral in the next, and computes the tilt check.
// ----------------------------------------------------------------------------
`default_nettype none

module rwbc_state_update (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  rwbc_pkg::input_t       in_stage,
  input  rwbc_pkg::cfg_t         cfg,
  output rwbc_pkg::loop_state_t  out_stage
);

  localparam logic signed [17:0] AI_MAX = 18'(rwbc_pkg::ANGLE_INTEGRAL_LIMIT);
  localparam logic signed [17:0] AI_MIN = -AI_MAX;
  localparam logic signed [24:0] SI_MAX = 25'(rwbc_pkg::SPEED_INT_LIMIT_Q8);
  localparam logic signed [24:0] SI_MIN = -SI_MAX;
  localparam logic [26:0] RECIP = 27'(rwbc_pkg::DIV10_RECIP);
  localparam int SH = rwbc_pkg::DIV10_SHIFT;

  typedef struct packed {
    logic               valid;
    logic               run_enable;
    logic               fallen;
    logic signed [16:0] bias;
    logic signed [12:0] angle_integral;
    logic signed [15:0] gyro_rate;
    logic signed [23:0] speed_filtered;
  } filt_stage_t;

  // Loop state.
  logic signed [12:0] angle_integral;
  logic signed [23:0] speed_filtered;
  logic signed [19:0] speed_integral;

  filt_stage_t filt;

  logic signed [16:0] bias;
  logic signed [17:0] ai_sum;
  logic signed [12:0] ai_next;
  logic signed [27:0] sf_ext;
  logic signed [27:0] err_ext;
  logic signed [27:0] numer;
  logic signed [27:0] numer_neg;
  logic [26:0]        mag;
  logic [53:0]        quot_prod;
  logic [23:0]        quot;
  logic signed [23:0] sf_next;
  logic signed [16:0] pitch_ext;
  logic signed [16:0] tilt_ext;
  logic               fallen;
  logic signed [24:0] si_sum;
  logic signed [19:0] si_next;

  // Angle integral, filter and tilt check.
  always_comb begin
    bias = {in_stage.pitch[15], in_stage.pitch}
         - {cfg.pitch_setpoint[15], cfg.pitch_setpoint};
    ai_sum = {{5{angle_integral[12]}}, angle_integral} + {bias[16], bias};
    if (ai_sum > AI_MAX) begin
      ai_next = AI_MAX[12:0];
    end else if (ai_sum < AI_MIN) begin
      ai_next = AI_MIN[12:0];
    end else begin
      ai_next = ai_sum[12:0];
    end

    // 7 * filtered + 768 * (-count), then truncating divide by ten.
    sf_ext    = {{4{speed_filtered[23]}}, speed_filtered};
    err_ext   = -{{12{in_stage.wheel_count[15]}}, in_stage.wheel_count};
    numer     = (sf_ext <<< 3) - sf_ext + (err_ext <<< 9) + (err_ext <<< 8);
    numer_neg = -numer;
    mag       = numer[27] ? numer_neg[26:0] : numer[26:0];
    quot_prod = {27'd0, mag} * {27'd0, RECIP};
    quot      = quot_prod[SH+23:SH];
    sf_next   = numer[27] ? -quot : quot;

    pitch_ext = {in_stage.pitch[15], in_stage.pitch};
    tilt_ext  = {2'b00, cfg.tilt_limit};
    fallen    = (pitch_ext > tilt_ext) || (pitch_ext < -tilt_ext);
  end

  // First stage registers and the angle/filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      filt.valid     <= 1'b0;
      angle_integral <= '0;
      speed_filtered <= '0;
    end else if (en) begin
      filt.valid <= in_stage.valid;
      if (in_stage.valid) begin
        angle_integral <= ai_next;
        speed_filtered <= in_stage.run_enable ? sf_next : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      filt.run_enable     <= in_stage.run_enable;
      filt.fallen         <= fallen;
      filt.bias           <= bias;
      filt.angle_integral <= ai_next;
      filt.gyro_rate      <= in_stage.gyro_rate;
      filt.speed_filtered <= sf_next;
    end
  end

  // Wheel speed integral.
  always_comb begin
    si_sum = {{5{speed_integral[19]}}, speed_integral}
           + {filt.speed_filtered[23], filt.speed_filtered};
    if (si_sum > SI_MAX) begin
      si_next = SI_MAX[19:0];
    end else if (si_sum < SI_MIN) begin
      si_next = SI_MIN[19:0];
    end else begin
      si_next = si_sum[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage.valid <= 1'b0;
      speed_integral  <= '0;
    end else if (en) begin
      out_stage.valid <= filt.valid;
      if (filt.valid) begin
        speed_integral <= filt.run_enable ? si_next : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage.run_enable     <= filt.run_enable;
      out_stage.fallen         <= filt.fallen;
      out_stage.bias           <= filt.bias;
      out_stage.angle_integral <= filt.angle_integral;
      out_stage.gyro_rate      <= filt.gyro_rate;
      out_stage.speed_filtered <= filt.speed_filtered;
      out_stage.speed_integral <= si_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rwbc_gain_mult.sv @@
// ----------------------------------------------------------------------------
// Gain multipliers
// Applies the loop gains to bias, integrals, gyro rate and filtered speed,
// and scales the angle products into the angle term.
// ----------------------------------------------------------------------------
`default_nettype none

module rwbc_gain_mult (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  rwbc_pkg::loop_state_t  in_stage,
  input  rwbc_pkg::cfg_t         cfg,
  output rwbc_pkg::terms_t       out_stage
);

  typedef struct packed {
    logic               valid;
    logic               run_enable;
    logic               fallen;
    logic signed [37:0] angle_p;
    logic signed [33:0] angle_i;
    logic signed [36:0] angle_d;
    logic signed [44:0] speed_p;
    logic signed [19:0] speed_integral;
  } prod_stage_t;

  prod_stage_t prod;

  logic signed [20:0] kp_s;
  logic signed [20:0] ki_s;
  logic signed [20:0] kd_s;
  logic signed [20:0] skp_s;
  logic signed [20:0] ski_s;
  logic signed [38:0] pi_sum;
  logic signed [38:0] pi_biased;
  logic signed [36:0] d_biased;
  logic signed [29:0] angle_term;
  logic signed [40:0] speed_i;

  always_comb begin
    kp_s  = {1'b0, cfg.angle_kp};
    ki_s  = {1'b0, cfg.angle_ki};
    kd_s  = {1'b0, cfg.angle_kd};
    skp_s = {1'b0, cfg.speed_kp};
    ski_s = {1'b0, cfg.speed_ki};
  end

  // Gain products.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else if (en) begin
      prod.valid <= in_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod.run_enable     <= in_stage.run_enable;
      prod.fallen         <= in_stage.fallen;
      prod.angle_p        <= kp_s * in_stage.bias;
      prod.angle_i        <= ki_s * in_stage.angle_integral;
      prod.angle_d        <= kd_s * in_stage.gyro_rate;
      prod.speed_p        <= skp_s * in_stage.speed_filtered;
      prod.speed_integral <= in_stage.speed_integral;
    end
  end

  // Angle term with truncation toward zero, and the speed integral product.
  always_comb begin
    pi_sum    = {prod.angle_p[37], prod.angle_p} + {{5{prod.angle_i[33]}}, prod.angle_i};
    pi_biased = pi_sum + (pi_sum[38] ? 39'sd32767 : 39'sd0);
    d_biased  = prod.angle_d + (prod.angle_d[36] ? 37'sd255 : 37'sd0);
    angle_term = {{6{pi_biased[38]}}, pi_biased[38:15]} + {d_biased[36], d_biased[36:8]};
    speed_i   = ski_s * prod.speed_integral;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage.valid <= 1'b0;
    end else if (en) begin
      out_stage.valid <= prod.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage.run_enable <= prod.run_enable;
      out_stage.fallen     <= prod.fallen;
      out_stage.angle_term <= angle_term;
      out_stage.speed_p    <= prod.speed_p;
      out_stage.speed_i    <= speed_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rwbc_duty_shaper.sv @@
// ----------------------------------------------------------------------------
// Duty shaper
// Combines angle and speed terms, then applies saturation, dead-zone offset,
// zero band and the fall cutoff; ends in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rwbc_duty_shaper (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  rwbc_pkg::terms_t   in_stage,
  input  rwbc_pkg::cfg_t     cfg,
  output rwbc_pkg::result_t  result
);

  localparam logic signed [15:0] OFFSET   = 16'(rwbc_pkg::DEAD_ZONE_OFFSET);
  localparam logic signed [15:0] BAND     = 16'(rwbc_pkg::ZERO_BAND);
  localparam logic signed [15:0] OUT_MAX  = 16'sd16383;
  localparam logic signed [15:0] OUT_MIN  = -16'sd16384;

  typedef struct packed {
    logic               valid;
    logic               fallen;
    logic signed [31:0] duty;
  } sum_stage_t;

  sum_stage_t sum_stage;

  logic signed [45:0] v_sum;
  logic signed [45:0] v_biased;
  logic signed [29:0] velocity;
  logic signed [31:0] duty_raw;
  logic signed [31:0] lim;
  logic signed [15:0] duty_sat;
  logic signed [15:0] duty_fin;

  // Velocity term and combined duty.
  always_comb begin
    v_sum    = {in_stage.speed_p[44], in_stage.speed_p}
             + {{5{in_stage.speed_i[40]}}, in_stage.speed_i};
    v_biased = v_sum + (v_sum[45] ? 46'sd65535 : 46'sd0);
    velocity = in_stage.run_enable ? v_biased[45:16] : '0;
    duty_raw = -({{2{in_stage.angle_term[29]}}, in_stage.angle_term}
               + {{2{velocity[29]}}, velocity});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_stage.valid <= 1'b0;
    end else if (en) begin
      sum_stage.valid <= in_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_stage.fallen <= in_stage.fallen;
      sum_stage.duty   <= duty_raw;
    end
  end

  // Saturation, dead-zone offset, zero band and fall cutoff.
  always_comb begin
    lim = {18'd0, cfg.duty_limit};
    if (sum_stage.duty > lim) begin
      duty_sat = lim[15:0];
    end else if (sum_stage.duty < -lim) begin
      duty_sat = -lim[15:0];
    end else if (sum_stage.duty < 0) begin
      duty_sat = sum_stage.duty[15:0] - OFFSET;
    end else if (sum_stage.duty > 0) begin
      duty_sat = sum_stage.duty[15:0] + OFFSET;
    end else begin
      duty_sat = '0;
    end

    if ((duty_sat < BAND && duty_sat > -BAND) || sum_stage.fallen) begin
      duty_fin = '0;
    end else if (duty_sat > OUT_MAX) begin
      duty_fin = OUT_MAX;
    end else if (duty_sat < OUT_MIN) begin
      duty_fin = OUT_MIN;
    end else begin
      duty_fin = duty_sat;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= sum_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.fallen     <= sum_stage.fallen;
      result.motor_duty <= duty_fin[14:0];
    end
  end

endmodule

`default_nettype wire
